FILE: rtl/rmul_pkg.sv
package rmul_pkg;

  localparam int NUM_COLS = 4;
  localparam int NUM_ROWS = 4;
  localparam int ELEM_W   = 32;
  localparam int ROW_W    = 2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MUL  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             req_type;
    logic [ROW_W-1:0] row;
  } ctl_t;

endpackage

FILE: rtl/rmul_req_if.sv
interface rmul_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic        [rmul_pkg::ROW_W-1:0]  row_index;
  logic signed [rmul_pkg::ELEM_W-1:0] elem0;
  logic signed [rmul_pkg::ELEM_W-1:0] elem1;
  logic signed [rmul_pkg::ELEM_W-1:0] elem2;
  logic signed [rmul_pkg::ELEM_W-1:0] elem3;

  modport source (output valid, req_type, row_index, elem0, elem1, elem2, elem3,
                  input ready);
  modport sink (input valid, req_type, row_index, elem0, elem1, elem2, elem3,
                output ready);
endinterface

FILE: rtl/rmul_rsp_if.sv
interface rmul_rsp_if;
  logic                               valid;
  logic                               ready;
  logic        [rmul_pkg::ROW_W-1:0]  out_row;
  logic signed [rmul_pkg::ELEM_W-1:0] prod0;
  logic signed [rmul_pkg::ELEM_W-1:0] prod1;
  logic signed [rmul_pkg::ELEM_W-1:0] prod2;
  logic signed [rmul_pkg::ELEM_W-1:0] prod3;

  modport source (output valid, out_row, prod0, prod1, prod2, prod3, input ready);
  modport sink (input valid, out_row, prod0, prod1, prod2, prod3, output ready);
endinterface

FILE: rtl/rmul_cell.sv
module rmul_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CELL_IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  rmul_pkg::ctl_t                ctl_in,
  input  logic signed [DATA_WIDTH-1:0]  elem_in [rmul_pkg::NUM_COLS],
  input  logic signed [2*DATA_WIDTH+1:0] sum_in [rmul_pkg::NUM_COLS],
  input  logic signed [2*DATA_WIDTH-1:0] prod_in [rmul_pkg::NUM_COLS],
  output rmul_pkg::ctl_t                ctl_out,
  output logic signed [DATA_WIDTH-1:0]  elem_out [rmul_pkg::NUM_COLS],
  output logic signed [2*DATA_WIDTH+1:0] sum_out [rmul_pkg::NUM_COLS],
  output logic signed [2*DATA_WIDTH-1:0] prod_out [rmul_pkg::NUM_COLS]
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W  = 2 * DATA_WIDTH + 2;
  localparam logic [rmul_pkg::ROW_W-1:0] MY_ROW = rmul_pkg::ROW_W'(CELL_IDX);

  // One row of the right-hand matrix lives in this cell.
  logic signed [DATA_WIDTH-1:0] row_q [rmul_pkg::NUM_COLS];
  logic                         load_hit;

  assign load_hit = en && ctl_in.valid && (ctl_in.req_type == rmul_pkg::REQ_LOAD) &&
                    (ctl_in.row == MY_ROW);

  always_ff @(posedge clk) begin
    if (load_hit) begin
      row_q <= elem_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      elem_out <= elem_in;
      for (int j = 0; j < rmul_pkg::NUM_COLS; j++) begin
        sum_out[j]  <= sum_in[j] + SUM_W'(prod_in[j]);
        prod_out[j] <= PROD_W'(elem_in[CELL_IDX]) * PROD_W'(row_q[j]);
      end
    end
  end

endmodule

FILE: rtl/rmul_sat.sv
module rmul_sat #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  rmul_pkg::ctl_t                 ctl_in,
  input  logic signed [2*DATA_WIDTH+1:0] sum_in [rmul_pkg::NUM_COLS],
  input  logic signed [2*DATA_WIDTH-1:0] prod_in [rmul_pkg::NUM_COLS],
  rmul_rsp_if.source                     rsp
);

  localparam int SUM_W = 2 * DATA_WIDTH + 2;
  localparam logic signed [SUM_W-1:0] MAXV =
    {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MINV = ~MAXV;

  logic signed [SUM_W-1:0]      total   [rmul_pkg::NUM_COLS];
  logic signed [SUM_W-1:0]      shifted [rmul_pkg::NUM_COLS];
  logic signed [DATA_WIDTH-1:0] sat     [rmul_pkg::NUM_COLS];
  logic signed [rmul_pkg::ELEM_W-1:0] prod_q [rmul_pkg::NUM_COLS];
  logic                         valid_q;
  logic [rmul_pkg::ROW_W-1:0]   row_q;

  always_comb begin
    for (int j = 0; j < rmul_pkg::NUM_COLS; j++) begin
      total[j]   = sum_in[j] + SUM_W'(prod_in[j]);
      shifted[j] = total[j] >>> FRAC_BITS;
      if (shifted[j] > MAXV) begin
        sat[j] = MAXV[DATA_WIDTH-1:0];
      end else if (shifted[j] < MINV) begin
        sat[j] = MINV[DATA_WIDTH-1:0];
      end else begin
        sat[j] = shifted[j][DATA_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= ctl_in.valid && (ctl_in.req_type == rmul_pkg::REQ_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_q <= ctl_in.row;
      for (int j = 0; j < rmul_pkg::NUM_COLS; j++) begin
        prod_q[j] <= rmul_pkg::ELEM_W'(sat[j]);
      end
    end
  end

  assign rsp.valid   = valid_q;
  assign rsp.out_row = row_q;
  assign rsp.prod0   = prod_q[0];
  assign rsp.prod1   = prod_q[1];
  assign rsp.prod2   = prod_q[2];
  assign rsp.prod3   = prod_q[3];

endmodule

FILE: rtl/matrix4x4_row_multiply_core.sv
// Channel  Dir  Beat
// req      in   req_type, row_index, elem0..elem3 (load a right row or multiply a left row)
// rsp      out  out_row, prod0..prod3 (one product row per multiply beat)
//
// A beat may enter every cycle while the chain is not stalled; its product row is registered through the
// chain of four row cells and then the round and saturate stage before it becomes valid.
// Reset clears the control path only; stored rows are undefined until loaded.
// The whole chain stalls while a product waits in the output register unread.
module matrix4x4_row_multiply_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  rmul_req_if.sink   req,
  rmul_rsp_if.source rsp
);

  localparam int NC     = rmul_pkg::NUM_COLS;
  localparam int NR     = rmul_pkg::NUM_ROWS;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W  = 2 * DATA_WIDTH + 2;

  logic                         en;
  rmul_pkg::ctl_t               ctl   [NR+1];
  logic signed [DATA_WIDTH-1:0] elem  [NR+1][NC];
  logic signed [SUM_W-1:0]      sum   [NR+1][NC];
  logic signed [PROD_W-1:0]     prod  [NR+1][NC];

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_comb begin
    ctl[0].valid    = req.valid;
    ctl[0].req_type = req.req_type;
    ctl[0].row      = req.row_index;
    elem[0][0] = req.elem0[DATA_WIDTH-1:0];
    elem[0][1] = req.elem1[DATA_WIDTH-1:0];
    elem[0][2] = req.elem2[DATA_WIDTH-1:0];
    elem[0][3] = req.elem3[DATA_WIDTH-1:0];
    for (int j = 0; j < NC; j++) begin
      sum[0][j]  = '0;
      prod[0][j] = '0;
    end
  end

  for (genvar k = 0; k < NR; k++) begin : g_cell
    rmul_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_IDX   (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl[k]),
      .elem_in  (elem[k]),
      .sum_in   (sum[k]),
      .prod_in  (prod[k]),
      .ctl_out  (ctl[k+1]),
      .elem_out (elem[k+1]),
      .sum_out  (sum[k+1]),
      .prod_out (prod[k+1])
    );
  end

  rmul_sat #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sat (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl[NR]),
    .sum_in  (sum[NR]),
    .prod_in (prod[NR]),
    .rsp     (rsp)
  );

endmodule

FILE: tb/matrix4x4_row_multiply_core_checker.sv
module matrix4x4_row_multiply_core_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  rmul_req_if  req,
  rmul_rsp_if  rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [rmul_pkg::ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [rmul_pkg::ROW_W-1:0]                          row;
    logic [rmul_pkg::NUM_COLS-1:0][rmul_pkg::ELEM_W-1:0] prod;
  } prod_row_t;

  localparam logic signed [65:0] SAT_MAX = (66'sd1 <<< (rmul_pkg::ELEM_W - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_MIN = -SAT_MAX - 66'sd1;

  elem_t     right_rows [rmul_pkg::NUM_ROWS][rmul_pkg::NUM_COLS];
  prod_row_t product_rows [$];
  int        fail_count = 0;

  assign errors = fail_count;

  function automatic elem_t column_product(input elem_t a [rmul_pkg::NUM_COLS], input int col);
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    acc = '0;
    for (int k = 0; k < rmul_pkg::NUM_ROWS; k++) begin
      acc = acc + (a[k] * right_rows[k][col]);
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > SAT_MAX) begin
      scaled = SAT_MAX;
    end else if (scaled < SAT_MIN) begin
      scaled = SAT_MIN;
    end
    return scaled[rmul_pkg::ELEM_W-1:0];
  endfunction

  function automatic void report_field(input string what, input int col, input logic [31:0] want,
                                       input logic [31:0] got);
    $display("%0t: %s%0d expected %0d (0x%08h) got %0d (0x%08h)", $time, what, col,
             $signed(want), want, $signed(got), got);
    fail_count++;
  endfunction

  always @(posedge clk) begin : monitor
    prod_row_t got;
    prod_row_t want;
    elem_t     a [rmul_pkg::NUM_COLS];
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.row     = rsp.out_row;
        got.prod[0] = rsp.prod0;
        got.prod[1] = rsp.prod1;
        got.prod[2] = rsp.prod2;
        got.prod[3] = rsp.prod3;
        if (product_rows.size() == 0) begin
          $display("%0t: product beat for row %0d with none expected", $time, got.row);
          fail_count++;
        end else begin
          want = product_rows.pop_front();
          if (got.row !== want.row) begin
            report_field("out_row", 0, 32'(want.row), 32'(got.row));
          end
          for (int j = 0; j < rmul_pkg::NUM_COLS; j++) begin
            if (got.prod[j] !== want.prod[j]) begin
              report_field("prod", j, want.prod[j], got.prod[j]);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        a[0] = req.elem0;
        a[1] = req.elem1;
        a[2] = req.elem2;
        a[3] = req.elem3;
        if (req.req_type == rmul_pkg::REQ_LOAD) begin
          for (int j = 0; j < rmul_pkg::NUM_COLS; j++) begin
            right_rows[req.row_index][j] = a[j];
          end
        end else begin
          want.row = req.row_index;
          for (int j = 0; j < rmul_pkg::NUM_COLS; j++) begin
            want.prod[j] = column_product(a, j);
          end
          product_rows.push_back(want);
        end
      end
    end
    pending <= product_rows.size();
  end

endmodule

FILE: tb/matrix4x4_row_multiply_core_tb.sv
module matrix4x4_row_multiply_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [rmul_pkg::ELEM_W-1:0] elem_t;

  localparam int    FRAC_BITS    = 16;
  localparam int    RANDOM_ROWS  = 650;
  localparam int    IDLE_LIMIT   = 2000;
  localparam elem_t ONE          = 32'sh0001_0000;
  localparam elem_t ELEM_MAX     = 32'sh7fff_ffff;
  localparam elem_t ELEM_MIN     = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   burst_left;
  int   idle_cycles = 0;
  int   stall_run = 0;
  int   stall_mode = 0;

  rmul_req_if req_ch ();
  rmul_rsp_if rsp_ch ();

  matrix4x4_row_multiply_core #(
    .DATA_WIDTH(rmul_pkg::ELEM_W),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  matrix4x4_row_multiply_core_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) product_check (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .errors (errors),
    .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: return ELEM_MAX;
          1: return ELEM_MIN;
          2: return '0;
          3: return -1;
          4: return 1;
          5: return ONE;
          default: return -ONE;
        endcase
      end
      2, 3: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
      default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  task automatic send_row(input logic kind, input logic [rmul_pkg::ROW_W-1:0] row,
                          input elem_t e [4]);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.row_index <= row;
    req_ch.elem0     <= e[0];
    req_ch.elem1     <= e[1];
    req_ch.elem2     <= e[2];
    req_ch.elem3     <= e[3];
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain_products();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(16, 64);
      end
      stall_run--;
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= (stall_run % 8 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("matrix4x4_row_multiply_core verification failed");
      $finish;
    end
  end

  initial begin
    elem_t row_elems [4];
    logic  kind;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= rmul_pkg::REQ_LOAD;
    req_ch.row_index <= '0;
    req_ch.elem0     <= '0;
    req_ch.elem1     <= '0;
    req_ch.elem2     <= '0;
    req_ch.elem3     <= '0;
    burst_left = $urandom_range(1, 8);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Identity first, so every product row is exact.
    for (int r = 0; r < rmul_pkg::NUM_ROWS; r++) begin
      row_elems = '{'0, '0, '0, '0};
      row_elems[r] = ONE;
      send_row(rmul_pkg::REQ_LOAD, rmul_pkg::ROW_W'(r), row_elems);
    end
    send_row(rmul_pkg::REQ_MUL, 0, '{2 * ONE, -3 * ONE, ONE / 2, ONE});
    send_row(rmul_pkg::REQ_MUL, 3, '{ELEM_MAX, ELEM_MIN, -1, '0});

    // Full-scale store: sums overflow in both directions and round toward minus infinity.
    for (int r = 0; r < rmul_pkg::NUM_ROWS; r++) begin
      send_row(rmul_pkg::REQ_LOAD, rmul_pkg::ROW_W'(r), '{ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX});
    end
    send_row(rmul_pkg::REQ_MUL, 1, '{ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX});
    send_row(rmul_pkg::REQ_MUL, 2, '{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN});
    send_row(rmul_pkg::REQ_MUL, 3, '{-1, -1, -1, -1});
    send_row(rmul_pkg::REQ_LOAD, 2, '{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN});
    send_row(rmul_pkg::REQ_MUL, 0, '{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN});
    send_row(rmul_pkg::REQ_MUL, 1, '{'0, '0, ELEM_MIN, '0});
    send_row(rmul_pkg::REQ_MUL, 2, '{1, '0, '0, '0});
    send_row(rmul_pkg::REQ_MUL, 3, '{-1, '0, '0, '0});
    send_row(rmul_pkg::REQ_MUL, 0, '{'0, '0, '0, '0});

    for (int i = 0; i < RANDOM_ROWS; i++) begin
      kind = ($urandom_range(0, 4) == 0) ? rmul_pkg::REQ_LOAD : rmul_pkg::REQ_MUL;
      for (int j = 0; j < 4; j++) begin
        row_elems[j] = rand_elem();
      end
      send_row(kind, rmul_pkg::ROW_W'($urandom_range(0, rmul_pkg::NUM_ROWS - 1)), row_elems);
      if (i % 250 == 120) begin
        drain_products();
      end
    end

    drain_products();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("matrix4x4_row_multiply_core verification clean");
    end else begin
      $display("matrix4x4_row_multiply_core verification failed");
    end
    $finish;
  end

endmodule
